// ===== rtl/rolling_decimal_counter_display_macros.svh =====
// Assertion macros for the rolling counter display.
`ifndef ROLLING_DECIMAL_COUNTER_DISPLAY_MACROS_SVH
`define ROLLING_DECIMAL_COUNTER_DISPLAY_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on a given clock and active-low reset.
`define RDCD_ASSERT_CLK(name, ck, rn, prop) \
	name: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("rolling counter display assertion failed");

// Check a property on the block clock and reset.
`define RDCD_ASSERT(name, prop) \
	`RDCD_ASSERT_CLK(name, clk, arst_n, prop)

`else

`define RDCD_ASSERT_CLK(name, ck, rn, prop)
`define RDCD_ASSERT(name, prop)

`endif

`endif

// ===== rtl/rdcd_pkg.sv =====
package rdcd_pkg;

	// Count limits and digit store size
	localparam logic [13:0] COUNT_MAX      = 14'd9999;
	localparam int          NUM_DIGITS_DEF = 4;
	localparam int          MAX_DIGITS     = 4;

	// Configuration register indexes
	localparam int          CFG_IDX_W      = 2;
	localparam logic [1:0]  CFG_LARGE_THR  = 2'd0;
	localparam logic [1:0]  CFG_MEDIUM_THR = 2'd1;
	localparam logic [1:0]  CFG_LARGE_STEP = 2'd2;
	localparam logic [1:0]  CFG_MEDIUM_STEP = 2'd3;

	// Configuration reset values
	localparam logic [13:0] LARGE_THR_RST   = 14'd100;
	localparam logic [13:0] MEDIUM_THR_RST  = 14'd10;
	localparam logic [13:0] LARGE_STEP_RST  = 14'd10;
	localparam logic [13:0] MEDIUM_STEP_RST = 14'd5;

	// Commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SNAP = 1'b1;

	// Sound event codes
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_DOWN     = 3'd1;
	localparam logic [2:0] EV_DOWN_END = 3'd2;
	localparam logic [2:0] EV_UP       = 3'd3;
	localparam logic [2:0] EV_UP_END   = 3'd4;
	localparam logic [2:0] EV_FULL     = 3'd5;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] target_amount;
		logic [13:0]        wallet_capacity;
		logic               meter_visible;
		logic               arm_max_notice;
	} in_t;

	typedef struct packed {
		logic [13:0] shown_value;
		logic [3:0]  digit_first;
		logic [3:0]  digit_second;
		logic [3:0]  digit_third;
		logic [3:0]  digit_fourth;
		logic [2:0]  digit_count;
		logic [2:0]  sound_event;
		logic        still_changing;
		logic        start_flourish;
		logic        at_capacity;
	} out_t;

	typedef struct packed {
		logic [13:0] large_gap_threshold;
		logic [13:0] medium_gap_threshold;
		logic [13:0] large_step;
		logic [13:0] medium_step;
	} cfg_t;

	// Number of significant decimal digits of a count
	function automatic logic [2:0] digit_count_of(logic [13:0] v);
		logic [2:0] n;
		if (v >= 14'd1000) n = 3'd4;
		else if (v >= 14'd100) n = 3'd3;
		else if (v >= 14'd10) n = 3'd2;
		else n = 3'd1;
		return n;
	endfunction

	// Split a count below 10000 into {thousands, hundreds, tens, ones}
	// with a ladder of parallel compares per decade.
	function automatic logic [15:0] split_digits(logic [13:0] v);
		logic [3:0] d_th;
		logic [3:0] d_hu;
		logic [3:0] d_te;
		logic [9:0] r_th;
		logic [6:0] r_hu;
		logic [3:0] r_te;
		d_th = '0;
		r_th = v[9:0];
		for (int k = 1; k <= 9; k++) begin
			if (v >= 14'(k * 1000)) begin
				d_th = 4'(k);
				r_th = 10'(v - 14'(k * 1000));
			end
		end
		d_hu = '0;
		r_hu = r_th[6:0];
		for (int k = 1; k <= 9; k++) begin
			if (r_th >= 10'(k * 100)) begin
				d_hu = 4'(k);
				r_hu = 7'(r_th - 10'(k * 100));
			end
		end
		d_te = '0;
		r_te = r_hu[3:0];
		for (int k = 1; k <= 9; k++) begin
			if (r_hu >= 7'(k * 10)) begin
				d_te = 4'(k);
				r_te = 4'(r_hu - 7'(k * 10));
			end
		end
		return {d_th, d_hu, d_te, r_te};
	endfunction

endpackage

// ===== rtl/rdcd_cfg_regs.sv =====
module rdcd_cfg_regs
	import rdcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [13:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.large_gap_threshold  <= LARGE_THR_RST;
			cfg_q.medium_gap_threshold <= MEDIUM_THR_RST;
			cfg_q.large_step           <= LARGE_STEP_RST;
			cfg_q.medium_step          <= MEDIUM_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LARGE_THR:   cfg_q.large_gap_threshold  <= cfg_data;
				CFG_MEDIUM_THR:  cfg_q.medium_gap_threshold <= cfg_data;
				CFG_LARGE_STEP:  cfg_q.large_step           <= cfg_data;
				CFG_MEDIUM_STEP: cfg_q.medium_step          <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/rdcd_step.sv =====
module rdcd_step
	import rdcd_pkg::*;
#(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  in_t  item,
	input  cfg_t cfg,
	output out_t result
);

	localparam int STORE_N = (NUM_DIGITS < MAX_DIGITS) ? NUM_DIGITS : MAX_DIGITS;

	logic [13:0] shown_q;
	logic        armed_q;
	logic [3:0]  store_q [STORE_N];

	logic [3:0]  old_dig [MAX_DIGITS];
	logic [3:0]  new_dig [MAX_DIGITS];
	logic [3:0]  src_dig [MAX_DIGITS];

	logic        armed_in;
	logic [13:0] target;
	logic        go_down;
	logic        go_up;
	logic [13:0] gap;
	logic [13:0] step;
	logic signed [15:0] dn_val;
	logic [14:0] up_val;
	logic        dn_hit;
	logic        up_hit;
	logic [13:0] next_val;
	logic        armed_next;
	logic        refresh;
	logic [2:0]  sound;
	logic        flourish;
	logic [2:0]  cnt;
	logic [15:0] split;
	logic [2:0]  src_idx;

	// Present stored digits; positions past the store read zero
	for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_old
		if (g < STORE_N) begin : g_st
			assign old_dig[g] = store_q[g];
		end else begin : g_zero
			assign old_dig[g] = '0;
		end
	end

	// Clamp the target and pick the step size
	always_comb begin
		armed_in = armed_q | item.arm_max_notice;
		if (item.target_amount[15]) target = '0;
		else if (item.target_amount[14] || item.target_amount[13:0] > COUNT_MAX)
			target = COUNT_MAX;
		else target = item.target_amount[13:0];

		go_down = (item.cmd == CMD_TICK) && (target < shown_q);
		go_up   = (item.cmd == CMD_TICK) && (target > shown_q);
		gap     = go_down ? (shown_q - target) : (target - shown_q);

		if (gap >= cfg.large_gap_threshold) step = cfg.large_step;
		else if (gap >= cfg.medium_gap_threshold) step = cfg.medium_step;
		else step = 14'd1;

		dn_val = $signed({2'b00, shown_q}) - $signed({2'b00, step});
		up_val = {1'b0, shown_q} + {1'b0, step};
		dn_hit = (dn_val == $signed({2'b00, target}));
		up_hit = (up_val == {1'b0, target});
	end

	// Move the count and decide sound, flourish and notice
	always_comb begin
		next_val   = shown_q;
		armed_next = armed_in;
		refresh    = 1'b0;
		sound      = EV_NONE;
		flourish   = 1'b0;
		if (item.cmd == CMD_SNAP) begin
			next_val = target;
			refresh  = 1'b1;
		end else if (go_down) begin
			refresh    = 1'b1;
			armed_next = 1'b0;
			next_val   = dn_val[15] ? '0 : dn_val[13:0];
			if (item.meter_visible) sound = dn_hit ? EV_DOWN_END : EV_DOWN;
		end else if (go_up) begin
			refresh  = 1'b1;
			next_val = (up_val > {1'b0, COUNT_MAX}) ? COUNT_MAX : up_val[13:0];
			if (item.meter_visible) begin
				if (up_hit) begin
					sound = EV_UP_END;
					if (armed_in) begin
						flourish   = 1'b1;
						armed_next = 1'b0;
					end
				end else begin
					sound = EV_UP;
				end
			end
		end else if (armed_in && target == item.wallet_capacity) begin
			sound      = EV_FULL;
			flourish   = 1'b1;
			armed_next = 1'b0;
		end
	end

	// Left-justify the new digits into the store; positions past the store stay zero
	always_comb begin
		cnt   = digit_count_of(next_val);
		split = split_digits(next_val);
		src_dig[0] = split[15:12];
		src_dig[1] = split[11:8];
		src_dig[2] = split[7:4];
		src_dig[3] = split[3:0];
		for (int j = 0; j < MAX_DIGITS; j++) begin
			src_idx = 3'(3'd4 - cnt + 3'(j));
			if (refresh && j < STORE_N && 3'(j) < cnt) new_dig[j] = src_dig[src_idx[1:0]];
			else new_dig[j] = old_dig[j];
		end
	end

	// Commit state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			armed_q <= 1'b0;
			for (int j = 0; j < STORE_N; j++) store_q[j] <= '0;
		end else if (fire) begin
			shown_q <= next_val;
			armed_q <= armed_next;
			for (int j = 0; j < STORE_N; j++) store_q[j] <= new_dig[j];
		end
	end

	// Form the result
	always_comb begin
		result.shown_value    = next_val;
		result.digit_first    = new_dig[0];
		result.digit_second   = new_dig[1];
		result.digit_third    = new_dig[2];
		result.digit_fourth   = new_dig[3];
		result.digit_count    = cnt;
		result.sound_event    = sound;
		result.still_changing = (next_val != target);
		result.start_flourish = flourish;
		result.at_capacity    = (next_val != '0) && (next_val == item.wallet_capacity);
	end

endmodule

// ===== rtl/rolling_decimal_counter_display.sv =====
// Rolling decimal counter display.
// Input channel (in_valid / in_stall / in_data): one transaction per frame
// tick or snap command, carrying the target count, wallet capacity and flags.
// Output channel (out_valid / out_stall / out_data): one result per input,
// with the shown count, four left-justified digits, digit count, sound event,
// changing, flourish and at-capacity flags.
// Configuration: cfg_we writes cfg_data into register cfg_index (gap
// thresholds and step sizes); write only while no transaction is in flight.
// Each result passes the input register, then the result register, before
// it is presented.
// Throughput: one transaction per cycle while out_stall is low; the shown
// count, digit store and notice flag update in the single step stage, so
// each item sees the state left by the one before.
// Reset clears the shown count, digits and notice flag and loads the
// configuration defaults. When out_stall is high the result holds and the
// input register fills; in_stall then rises until the output drains.
`include "rolling_decimal_counter_display_macros.svh"

module rolling_decimal_counter_display
	import rdcd_pkg::*;
#(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [13:0]          cfg_data
);

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	out_t result;
	out_t out_q;
	logic out_valid_q;
	logic adv;
	logic fire;

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	rdcd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
	end

	rdcd_step #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`RDCD_ASSERT(a_shown_in_range, out_valid |-> out_data.shown_value <= COUNT_MAX)
	`RDCD_ASSERT(a_count_matches, out_valid |-> out_data.digit_count == digit_count_of(out_data.shown_value))
	`RDCD_ASSERT(a_flourish_event, (out_valid && out_data.start_flourish) |-> (out_data.sound_event == EV_UP_END || out_data.sound_event == EV_FULL))
	`RDCD_ASSERT(a_held_item_stays, (valid_s1 && !adv) |=> valid_s1)

endmodule

// ===== bench/rolling_decimal_counter_display_test.sv =====
`timescale 1ns / 100ps

module rolling_decimal_counter_display_test;
	import rdcd_pkg::*;

	localparam int QUIET_LIMIT  = 1000;
	localparam int REPORT_LIMIT = 10;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_ITEMS  = 270;

	// Tracks the rolling count, digit store and notice flag; queues the frames it predicts
	class shown_count_tracker;
		logic [13:0] large_thr;
		logic [13:0] medium_thr;
		logic [13:0] large_amt;
		logic [13:0] medium_amt;
		int          shown;
		logic [3:0]  digits [4];
		bit          armed;
		out_t        awaited [$];
		int          mismatches;

		function new();
			large_thr  = LARGE_THR_RST;
			medium_thr = MEDIUM_THR_RST;
			large_amt  = LARGE_STEP_RST;
			medium_amt = MEDIUM_STEP_RST;
			shown      = 0;
			foreach (digits[i]) digits[i] = '0;
			armed      = 0;
			mismatches = 0;
		endfunction

		function int step_size(int gap);
			if (gap >= int'(large_thr)) return int'(large_amt);
			if (gap >= int'(medium_thr)) return int'(medium_amt);
			return 1;
		endfunction

		function int decimal_width(int v);
			if (v >= 1000) return 4;
			if (v >= 100) return 3;
			if (v >= 10) return 2;
			return 1;
		endfunction

		// Rewrite the leading digits only; trailing entries keep stale values
		function void load_digits(int v);
			int n;
			int scale;
			n = decimal_width(v);
			scale = 1;
			for (int i = 1; i < n; i++) scale = scale * 10;
			for (int i = 0; i < n; i++) begin
				digits[i] = 4'((v / scale) % 10);
				scale = scale / 10;
			end
		endfunction

		function void note_target(in_t t);
			int   goal;
			int   nxt;
			int   cap;
			out_t r;
			r = '0;
			cap = int'(t.wallet_capacity);
			if (t.arm_max_notice) armed = 1;
			// clamp the signed target into the display range
			if (t.target_amount[15]) goal = 0;
			else goal = int'(t.target_amount[14:0]);
			if (goal > int'(COUNT_MAX)) goal = int'(COUNT_MAX);
			if (t.cmd == CMD_SNAP) begin
				shown = goal;
				load_digits(shown);
			end else if (goal != shown) begin
				if (goal < shown) begin
					nxt = shown - step_size(shown - goal);
					if (t.meter_visible) r.sound_event = (nxt == goal) ? EV_DOWN_END : EV_DOWN;
					armed = 0;
				end else begin
					nxt = shown + step_size(goal - shown);
					if (t.meter_visible) begin
						if (nxt == goal) begin
							r.sound_event = EV_UP_END;
							if (armed) begin
								r.start_flourish = 1'b1;
								armed = 0;
							end
						end else begin
							r.sound_event = EV_UP;
						end
					end
				end
				// overshoot is clamped only to the display range
				if (nxt < 0) nxt = 0;
				if (nxt > int'(COUNT_MAX)) nxt = int'(COUNT_MAX);
				shown = nxt;
				load_digits(shown);
			end else if (armed && goal == cap) begin
				r.sound_event = EV_FULL;
				r.start_flourish = 1'b1;
				armed = 0;
			end
			r.shown_value    = 14'(shown);
			r.digit_first    = digits[0];
			r.digit_second   = digits[1];
			r.digit_third    = digits[2];
			r.digit_fourth   = digits[3];
			r.digit_count    = 3'(decimal_width(shown));
			r.still_changing = (shown != goal);
			r.at_capacity    = (shown != 0 && shown == cap);
			awaited.push_back(r);
		endfunction

		function void flag(string what, logic [13:0] want, logic [13:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch on %s: expected %0d, got %0d", what, want, got);
			end
		endfunction

		function void check_frame(out_t got);
			out_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: expected none, got shown_value %0d",
						got.shown_value);
				return;
			end
			want = awaited.pop_front();
			flag("shown_value", want.shown_value, got.shown_value);
			flag("digit_first", want.digit_first, got.digit_first);
			flag("digit_second", want.digit_second, got.digit_second);
			flag("digit_third", want.digit_third, got.digit_third);
			flag("digit_fourth", want.digit_fourth, got.digit_fourth);
			flag("digit_count", want.digit_count, got.digit_count);
			flag("sound_event", want.sound_event, got.sound_event);
			flag("still_changing", want.still_changing, got.still_changing);
			flag("start_flourish", want.start_flourish, got.start_flourish);
			flag("at_capacity", want.at_capacity, got.at_capacity);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [13:0]          cfg_data;

	shown_count_tracker tracker;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked   = 0;
	int goal_hint     = 0;

	rolling_decimal_counter_display uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drive result-side stall; serve long hold-offs when asked
	initial begin
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) tracker.check_frame(out_data);
	end

	// Abort when neither channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic in_t frame(logic c, int tgt, int cap, logic vis, logic arm);
		in_t t;
		t.cmd             = c;
		t.target_amount   = 16'(tgt);
		t.wallet_capacity = 14'(cap);
		t.meter_visible   = vis;
		t.arm_max_notice  = arm;
		return t;
	endfunction

	// Mostly repeated ticks toward a goal near the shown count, with some noise
	function automatic in_t random_frame();
		int pick;
		int tgt;
		int near;
		int cap;
		if ($urandom_range(99) < 12) begin
			pick = $urandom_range(99);
			if (pick < 60) goal_hint = tracker.shown + int'($urandom_range(400)) - 200;
			else if (pick < 75) goal_hint = $urandom_range(9999);
			else if (pick < 85) goal_hint = (pick % 2 == 1) ? 0 : int'(COUNT_MAX);
			else goal_hint = int'($signed(16'($urandom)));
		end
		tgt = goal_hint;
		if ($urandom_range(99) < 5) tgt = int'($signed(16'($urandom)));
		near = (tgt < 0) ? 0 : (tgt > int'(COUNT_MAX)) ? int'(COUNT_MAX) : tgt;
		pick = $urandom_range(99);
		if (pick < 55) cap = near;
		else if (pick < 70) cap = tracker.shown;
		else if (pick < 90) cap = $urandom_range(9999);
		else cap = $urandom_range(16383);
		return frame(($urandom_range(9) == 0) ? CMD_SNAP : CMD_TICK, tgt, cap,
			$urandom_range(99) < 80, $urandom_range(99) < 20);
	endfunction

	// Offer one transaction, idling first at random; hold it until accepted
	task automatic offer_frame(input in_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do @(posedge clk); while (in_stall);
		tracker.note_target(t);
		@(negedge clk);
	endtask

	// Drop valid and wait for every predicted frame, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [13:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [13:0] lt, input logic [13:0] mt,
		input logic [13:0] ls, input logic [13:0] ms);
		write_reg(CFG_LARGE_THR, lt);
		write_reg(CFG_MEDIUM_THR, mt);
		write_reg(CFG_LARGE_STEP, ls);
		write_reg(CFG_MEDIUM_STEP, ms);
		cfg_we <= 1'b0;
		tracker.large_thr  = lt;
		tracker.medium_thr = mt;
		tracker.large_amt  = ls;
		tracker.medium_amt = ms;
	endtask

	task automatic run_phase(input int snd, input int rcv);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
		repeat (PHASE_ITEMS) offer_frame(random_frame());
		settle();
	endtask

	initial begin
		tracker   = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: extremes of target, every event, stale digits
		offer_frame(frame(CMD_SNAP, 0, 0, 1, 0));
		offer_frame(frame(CMD_TICK, 32767, 9999, 1, 1));
		offer_frame(frame(CMD_TICK, -32768, 0, 1, 0));
		offer_frame(frame(CMD_SNAP, 9999, 9999, 0, 1));
		offer_frame(frame(CMD_TICK, 9999, 9999, 0, 0));
		offer_frame(frame(CMD_TICK, 9990, 9999, 1, 0));
		offer_frame(frame(CMD_TICK, 10000, 9999, 1, 0));
		holds_asked++;
		offer_frame(frame(CMD_SNAP, 1234, 16383, 1, 0));
		offer_frame(frame(CMD_SNAP, 5, 0, 1, 0));
		offer_frame(frame(CMD_SNAP, 1234, 0, 1, 0));
		offer_frame(frame(CMD_TICK, 1000, 0, 1, 0));
		offer_frame(frame(CMD_SNAP, 14, 15, 1, 0));
		offer_frame(frame(CMD_TICK, 15, 15, 1, 1));
		offer_frame(frame(CMD_TICK, 25, 0, 0, 1));
		offer_frame(frame(CMD_SNAP, 11, 0, 1, 0));
		offer_frame(frame(CMD_TICK, 10, 0, 1, 0));
		offer_frame(frame(CMD_TICK, 10, 10, 1, 1));
		offer_frame(frame(CMD_TICK, -1, 0, 1, 0));
		settle();

		// Huge steps and unit thresholds: overshoot both ways
		load_config(14'd1, 14'd1, 14'd9999, 14'd9999);
		offer_frame(frame(CMD_TICK, 0, 0, 1, 0));
		offer_frame(frame(CMD_SNAP, 9000, 0, 1, 0));
		offer_frame(frame(CMD_TICK, 9999, 0, 1, 1));
		offer_frame(frame(CMD_TICK, 9999, 9999, 1, 0));
		settle();

		// Zero steps never move; zero thresholds always match
		load_config(14'd0, 14'd0, 14'd0, 14'd0);
		offer_frame(frame(CMD_TICK, 50, 0, 1, 0));
		offer_frame(frame(CMD_SNAP, 3, 0, 1, 0));
		offer_frame(frame(CMD_TICK, 7, 0, 1, 0));
		settle();

		// All-ones registers: thresholds out of reach
		load_config(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
		offer_frame(frame(CMD_TICK, 9999, 0, 1, 0));
		settle();

		load_config(14'($urandom_range(500, 20)), 14'($urandom_range(19, 2)),
			14'($urandom_range(60, 2)), 14'($urandom_range(9, 2)));
		run_phase(16, 79);

		load_config(14'd9999, 14'd1, 14'd9999, 14'($urandom_range(9, 1)));
		run_phase(79, 16);

		load_config(14'($urandom_range(300, 10)), 14'($urandom_range(9, 1)),
			14'($urandom_range(40, 1)), 14'($urandom_range(9, 1)));
		holds_asked++;
		run_phase(0, 0);

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
